/* hw/rtl/sit_pkg.sv */
// shared types, codes and command/status words of the stacking item table
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

	localparam int OPCODE_W   = 2;
	localparam int KIND_W     = 3;
	localparam int POS_W      = 8;
	localparam int AMOUNT_W   = 16;
	localparam int SLOT_IN_W  = 8;
	localparam int SLOT_OUT_W = 6;
	localparam int TOTAL_W    = 22;

	localparam logic [OPCODE_W-1:0] OP_ADD  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_FIND = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_TAKE = 2'd2;

	localparam logic [KIND_W-1:0] KIND_ANY   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_WOOD  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_STONE = 3'd2;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef struct packed {
		logic [OPCODE_W-1:0]  opcode;
		logic [KIND_W-1:0]    item_kind;
		logic [POS_W-1:0]     pos_x;
		logic [POS_W-1:0]     pos_y;
		logic [AMOUNT_W-1:0]  amount;
		logic [SLOT_IN_W-1:0] slot_in;
	} sit_req_t;

	typedef struct packed {
		logic                  ok;
		logic [SLOT_OUT_W-1:0] slot_out;
		logic [TOTAL_W-1:0]    wood_total;
		logic [TOTAL_W-1:0]    stone_total;
	} sit_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_CLAIM,
		ST_TREAD,
		ST_TCAP,
		ST_CALC,
		ST_COMMIT,
		ST_RESP
	} sit_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic claim;
		logic rd_take;
		logic cap;
		logic calc;
		logic commit;
		logic resp;
		logic ok;
	} sit_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic                zero_amt;
		logic                take_ok;
		logic                hit;
		logic                scan_done;
		logic                free_any;
		logic                out_free;
	} sit_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/stacking_item_table.sv */
// Stacking item table: a table of SLOTS slots, each holding a kind, a position and a count.
// Add and find walk the table one slot per cycle through the single read port of the slot
// memory; a find stops at the first slot that hits and an add at the first slot it merges
// into. A miss walks the whole table, after which an add claims the first free slot, if any.
// Take reads its one slot directly, and a failing take, a zero add or an unused opcode
// answers without touching the table. One word is worked on at a time; the next request
// word is accepted as soon as the previous result sits in the output register, even if it
// has not been taken yet. Used marks are flip-flops cleared by reset, so the table is usable
// straight after reset. Wood and stone totals are kept as running sums and reported,
// saturated at 4194303, with every result.
`timescale 1ns / 1ps
`default_nettype none

module stacking_item_table import sit_pkg::*; #(
	parameter int SLOTS      = 64,
	parameter int COUNT_BITS = 16,
	parameter int COORD_BITS = 8
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire sit_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output sit_rsp_t      rsp
);

	sit_cmd_t cmd;
	sit_sts_t sts;

	sit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sit_datapath #(
		.SLOTS      (SLOTS),
		.COUNT_BITS (COUNT_BITS),
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

/* hw/rtl/sit_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module sit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/sit_ctrl.sv */
// controller state machine of the stacking item table
`timescale 1ns / 1ps
`default_nettype none

module sit_ctrl import sit_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire sit_sts_t sts,
	output sit_cmd_t      cmd
);

	sit_state_t state_q, state_d;
	logic       ok_q, ok_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ok_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ok_d      = ok_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				ok_d = 1'b0;
				unique case (sts.op)
					OP_ADD:  state_d = sts.zero_amt ? ST_RESP : ST_SCAN;
					OP_FIND: state_d = ST_SCAN;
					OP_TAKE: state_d = sts.take_ok ? ST_TREAD : ST_RESP;
					default: state_d = ST_RESP;
				endcase
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					if (sts.op == OP_FIND) begin
						ok_d    = 1'b1;
						state_d = ST_RESP;
					end else begin
						state_d = ST_CALC;
					end
				end else if (sts.scan_done) begin
					if (sts.op == OP_ADD && sts.free_any) begin
						state_d = ST_CLAIM;
					end else begin
						ok_d    = 1'b0;
						state_d = ST_RESP;
					end
				end
			end
			ST_CLAIM: begin
				cmd.claim = 1'b1;
				state_d   = ST_CALC;
			end
			ST_TREAD: begin
				cmd.rd_take = 1'b1;
				state_d     = ST_TCAP;
			end
			ST_TCAP: begin
				cmd.cap = 1'b1;
				state_d = ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				ok_d       = 1'b1;
				state_d    = ST_RESP;
			end
			ST_RESP: begin
				cmd.ok = ok_q;
				if (sts.out_free) begin
					cmd.resp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/sit_datapath.sv */
// datapath of the stacking item table: slot memory, used marks, scan, totals, output register
`timescale 1ns / 1ps
`default_nettype none

module sit_datapath import sit_pkg::*; #(
	parameter int SLOTS      = 64,
	parameter int COUNT_BITS = 16,
	parameter int COORD_BITS = 8
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire sit_req_t req,
	input  wire sit_cmd_t cmd,
	output sit_sts_t      sts,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output sit_rsp_t      rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = IW + 1;
	localparam int TW = COUNT_BITS + IW;
	localparam int WB = (COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W;
	localparam int SW = (TW > TOTAL_W) ? TW : TOTAL_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COUNT_BITS-1:0] count;
	} ent_t;

	localparam int EW = $bits(ent_t);

	sit_req_t              req_q;
	logic [SLOTS-1:0]      used_q;
	logic [CW-1:0]         rd_cnt_q;
	logic                  cmp_vld_s1;
	logic [IW-1:0]         cmp_idx_s1;
	logic                  free_fnd_q;
	logic [IW-1:0]         free_idx_q;
	logic [IW-1:0]         tgt_idx_q;
	logic [KIND_W-1:0]     tgt_kind_q;
	logic [COORD_BITS-1:0] tgt_x_q;
	logic [COORD_BITS-1:0] tgt_y_q;
	logic [COUNT_BITS-1:0] old_q;
	logic [COUNT_BITS-1:0] delta_q;
	logic                  free_q;
	logic [TW-1:0]         wood_q;
	logic [TW-1:0]         stone_q;
	sit_rsp_t              rsp_q;
	logic                  rsp_valid_q;

	logic [COORD_BITS-1:0] x_in, y_in;
	logic                  is_add, is_find;
	logic                  rd_issue, rd_en;
	logic [IW-1:0]         rd_addr;
	logic [EW-1:0]         rd_data, wr_data;
	ent_t                  rd_ent, wr_ent;
	logic                  slot_used_c, kind_match, hit, free_now;
	logic [COUNT_BITS-1:0] lim, delta_c, new_cnt;
	logic                  amt_lt;
	logic [SW-1:0]         wood_w, stone_w;
	logic                  out_free;

	assign x_in    = COORD_BITS'(req_q.pos_x);
	assign y_in    = COORD_BITS'(req_q.pos_y);
	assign is_add  = (req_q.opcode == OP_ADD);
	assign is_find = (req_q.opcode == OP_FIND);

	// one slot read per cycle while scanning, compared in the cycle after its read
	assign rd_issue = cmd.scan && (rd_cnt_q < CW'(SLOTS));
	assign rd_en    = rd_issue || cmd.rd_take;
	assign rd_addr  = cmd.rd_take ? tgt_idx_q : rd_cnt_q[IW-1:0];
	assign rd_ent   = rd_data;

	assign slot_used_c = used_q[cmp_idx_s1];
	assign kind_match  = (is_find && req_q.item_kind == KIND_ANY) ||
		(rd_ent.kind == req_q.item_kind);
	assign hit      = cmp_vld_s1 && slot_used_c && rd_ent.x == x_in && rd_ent.y == y_in &&
		kind_match;
	assign free_now = cmp_vld_s1 && !slot_used_c;

	// add is limited by the room left, take by the count held
	assign lim     = is_add ? (COUNT_MAX - old_q) : old_q;
	assign amt_lt  = WB'(req_q.amount) < WB'(lim);
	assign delta_c = amt_lt ? COUNT_BITS'(req_q.amount) : lim;
	assign new_cnt = is_add ? (old_q + delta_q) : (old_q - delta_q);

	assign wr_ent.kind  = tgt_kind_q;
	assign wr_ent.x     = tgt_x_q;
	assign wr_ent.y     = tgt_y_q;
	assign wr_ent.count = new_cnt;
	assign wr_data      = wr_ent;

	assign out_free = !rsp_valid_q || rsp_ready;

	assign sts.op        = req_q.opcode;
	assign sts.zero_amt  = (req_q.amount == '0);
	assign sts.take_ok   = ({1'b0, req_q.slot_in} < (SLOT_IN_W + 1)'(SLOTS)) &&
		used_q[req_q.slot_in[IW-1:0]];
	assign sts.hit       = hit;
	assign sts.scan_done = cmp_vld_s1 && (cmp_idx_s1 == IW'(SLOTS - 1));
	assign sts.free_any  = free_fnd_q || free_now;
	assign sts.out_free  = out_free;

	assign wood_w  = SW'(wood_q);
	assign stone_w = SW'(stone_q);

	sit_ram #(
		.WIDTH (EW),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (tgt_idx_q),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			rd_cnt_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			free_fnd_q  <= 1'b0;
			wood_q      <= '0;
			stone_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_cnt_q   <= '0;
				cmp_vld_s1 <= 1'b0;
				free_fnd_q <= 1'b0;
			end else begin
				cmp_vld_s1 <= rd_issue;
				if (rd_issue) begin
					rd_cnt_q <= rd_cnt_q + CW'(1);
				end
				if (cmd.scan && free_now) begin
					free_fnd_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				used_q[tgt_idx_q] <= is_add || !free_q;
				if (tgt_kind_q == KIND_WOOD) begin
					wood_q <= is_add ? (wood_q + TW'(delta_q)) : (wood_q - TW'(delta_q));
				end
				if (tgt_kind_q == KIND_STONE) begin
					stone_q <= is_add ? (stone_q + TW'(delta_q)) : (stone_q - TW'(delta_q));
				end
			end
			if (cmd.resp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= req;
			tgt_idx_q <= IW'(req.slot_in);
		end
		if (rd_issue) begin
			cmp_idx_s1 <= rd_cnt_q[IW-1:0];
		end
		if (cmd.scan && free_now && !free_fnd_q) begin
			free_idx_q <= cmp_idx_s1;
		end
		if ((cmd.scan && hit) || cmd.cap) begin
			if (cmd.scan) begin
				tgt_idx_q <= cmp_idx_s1;
			end
			tgt_kind_q <= rd_ent.kind;
			tgt_x_q    <= rd_ent.x;
			tgt_y_q    <= rd_ent.y;
			old_q      <= rd_ent.count;
		end
		if (cmd.claim) begin
			tgt_idx_q  <= free_idx_q;
			tgt_kind_q <= req_q.item_kind;
			tgt_x_q    <= x_in;
			tgt_y_q    <= y_in;
			old_q      <= '0;
		end
		if (cmd.calc) begin
			delta_q <= delta_c;
			free_q  <= !is_add && !amt_lt;
		end
		if (cmd.resp) begin
			rsp_q.ok          <= cmd.ok;
			rsp_q.slot_out    <= cmd.ok ? SLOT_OUT_W'(tgt_idx_q) : '0;
			rsp_q.wood_total  <= (wood_w > SW'(TOTAL_MAX)) ? TOTAL_MAX : wood_w[TOTAL_W-1:0];
			rsp_q.stone_total <= (stone_w > SW'(TOTAL_MAX)) ? TOTAL_MAX :
				stone_w[TOTAL_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_add_marks_used: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && is_add |=> used_q[tgt_idx_q])
		else $error("add commit left its slot unused");

	a_take_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !is_add && free_q |=> !used_q[tgt_idx_q])
		else $error("emptying take left its slot used");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.calc && is_add && old_q != COUNT_MAX |=> delta_q != '0)
		else $error("add below the count limit added nothing");

	a_totals_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(wood_q) && $stable(stone_q))
		else $error("totals moved outside a commit");

endmodule

`default_nettype wire

/* tb/sit_checker.sv */
// checker for the stacking item table: watches both channels, predicts each result and compares
`timescale 1ns / 1ps

module sit_checker import sit_pkg::*; #(
	parameter int SLOTS = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	input  wire logic     req_ready,
	input  wire sit_req_t req,
	input  wire logic     rsp_valid,
	input  wire logic     rsp_ready,
	input  wire sit_rsp_t rsp,
	output int            mismatches,
	output int            outstanding
);

	localparam int COUNT_BITS = AMOUNT_W;

	// shadow copy of the slot table
	logic                  stack_used  [SLOTS];
	logic [KIND_W-1:0]     stack_kind  [SLOTS];
	logic [POS_W-1:0]      stack_x     [SLOTS];
	logic [POS_W-1:0]      stack_y     [SLOTS];
	logic [COUNT_BITS-1:0] stack_count [SLOTS];

	sit_rsp_t predicted_rsp [$];

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns sit_checker: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// applies one request word to the shadow table and returns the result it should give
	function automatic sit_rsp_t step_table(input sit_req_t w);
		sit_rsp_t            r;
		int                  hit;
		int                  i;
		logic [COUNT_BITS:0] sum;
		longint              wood;
		longint              stone;
		hit = -1;
		case (w.opcode)
			OP_ADD: begin
				if (w.amount != '0) begin
					for (i = 0; i < SLOTS && hit < 0; i++) begin
						if (stack_used[i] && stack_kind[i] == w.item_kind &&
								stack_x[i] == w.pos_x && stack_y[i] == w.pos_y) begin
							hit = i;
							sum = {1'b0, stack_count[i]} + {1'b0, w.amount};
							stack_count[i] = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
						end
					end
					for (i = 0; i < SLOTS && hit < 0; i++) begin
						if (!stack_used[i]) begin
							hit            = i;
							stack_used[i]  = 1'b1;
							stack_kind[i]  = w.item_kind;
							stack_x[i]     = w.pos_x;
							stack_y[i]     = w.pos_y;
							stack_count[i] = w.amount;
						end
					end
				end
			end
			OP_FIND: begin
				for (i = 0; i < SLOTS && hit < 0; i++) begin
					if (stack_used[i] && stack_x[i] == w.pos_x && stack_y[i] == w.pos_y &&
							(w.item_kind == KIND_ANY || stack_kind[i] == w.item_kind))
						hit = i;
				end
			end
			OP_TAKE: begin
				if (int'(w.slot_in) < SLOTS && stack_used[w.slot_in]) begin
					hit = int'(w.slot_in);
					if (w.amount >= stack_count[hit]) begin
						stack_used[hit]  = 1'b0;
						stack_count[hit] = '0;
					end else begin
						stack_count[hit] = stack_count[hit] - w.amount;
					end
				end
			end
			default: begin
			end
		endcase
		wood  = 0;
		stone = 0;
		for (i = 0; i < SLOTS; i++) begin
			if (stack_used[i] && stack_kind[i] == KIND_WOOD)
				wood += longint'(stack_count[i]);
			if (stack_used[i] && stack_kind[i] == KIND_STONE)
				stone += longint'(stack_count[i]);
		end
		if (wood > TOTAL_MAX)
			wood = TOTAL_MAX;
		if (stone > TOTAL_MAX)
			stone = TOTAL_MAX;
		r.ok          = (hit >= 0);
		r.slot_out    = (hit >= 0) ? hit[SLOT_OUT_W-1:0] : '0;
		r.wood_total  = wood[TOTAL_W-1:0];
		r.stone_total = stone[TOTAL_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sit_rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				stack_used[i]  = 1'b0;
				stack_kind[i]  = '0;
				stack_x[i]     = '0;
				stack_y[i]     = '0;
				stack_count[i] = '0;
			end
			predicted_rsp.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (predicted_rsp.size() == 0) begin
					report_mismatch("result word with nothing predicted, slot_out", rsp.slot_out, -1);
				end else begin
					want = predicted_rsp.pop_front();
					if (rsp.ok !== want.ok)
						report_mismatch("ok", rsp.ok, want.ok);
					if (rsp.slot_out !== want.slot_out)
						report_mismatch("slot_out", rsp.slot_out, want.slot_out);
					if (rsp.wood_total !== want.wood_total)
						report_mismatch("wood_total", rsp.wood_total, want.wood_total);
					if (rsp.stone_total !== want.stone_total)
						report_mismatch("stone_total", rsp.stone_total, want.stone_total);
				end
			end
			if (req_valid && req_ready)
				predicted_rsp.push_back(step_table(req));
			outstanding <= predicted_rsp.size();
		end
	end

endmodule

/* tb/tb_top.sv */
// top of the stacking item table testbench: clock, reset, request and result stimulus, verdict
`timescale 1ns / 1ps

module tb_top;
	import sit_pkg::*;

	localparam int SLOTS    = 64;
	localparam int LIMIT_NS = 2_000_000;

	localparam logic [OPCODE_W-1:0] OP_NONE    = 2'd3;
	localparam logic [KIND_W-1:0]   KIND_BED   = 3'd3;
	localparam logic [KIND_W-1:0]   KIND_CHAIR = 3'd4;
	localparam logic [KIND_W-1:0]   KIND_SPARE = 3'd7;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	sit_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	sit_rsp_t rsp;
	logic     steady    = 1'b0;
	int       mismatches;
	int       outstanding;

	stacking_item_table #(.SLOTS(SLOTS)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	sit_checker #(.SLOTS(SLOTS)) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #1 clk = ~clk;

	// result side stalls about one cycle in five unless held steady
	always @(posedge clk) begin
		rsp_ready <= steady || ($urandom_range(0, 99) >= 20);
	end

	initial begin
		#(LIMIT_NS);
		$display("stacking_item_table regression: fail");
		$finish;
	end

	function automatic sit_req_t make_word(input logic [OPCODE_W-1:0] op,
			input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
			input logic [AMOUNT_W-1:0] amount, input logic [SLOT_IN_W-1:0] slot);
		sit_req_t w;
		w.opcode    = op;
		w.item_kind = kind;
		w.pos_x     = x;
		w.pos_y     = y;
		w.amount    = amount;
		w.slot_in   = slot;
		return w;
	endfunction

	// narrow positions make merges and find hits common, spread ones claim fresh slots
	function automatic sit_req_t random_word(input int add_pct, input int take_pct,
			input bit spread);
		sit_req_t    w;
		logic [31:0] r;
		int          roll;
		roll = $urandom_range(0, 99);
		if (roll < add_pct)
			w.opcode = OP_ADD;
		else if (roll < add_pct + take_pct)
			w.opcode = OP_TAKE;
		else if (roll < 97)
			w.opcode = OP_FIND;
		else
			w.opcode = OP_NONE;
		r = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7);
		w.item_kind = r[KIND_W-1:0];
		r = (spread || $urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3);
		w.pos_x = r[POS_W-1:0];
		r = (spread || $urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3);
		w.pos_y = r[POS_W-1:0];
		roll = $urandom_range(0, 99);
		if (roll < 5)
			r = 0;
		else if (roll < 15)
			r = $urandom;
		else if (roll < 20)
			r = $urandom_range(65000, 65535);
		else
			r = $urandom_range(1, 300);
		w.amount = r[AMOUNT_W-1:0];
		roll = $urandom_range(0, 99);
		if (roll < 15)
			r = $urandom;
		else if (roll < 60)
			r = $urandom_range(0, 7);
		else
			r = $urandom_range(0, SLOTS - 1);
		w.slot_in = r[SLOT_IN_W-1:0];
		return w;
	endfunction

	task automatic send_word(input sit_req_t w);
		int gap;
		if (!steady && $urandom_range(0, 99) < 20) begin
			req_valid <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 90) : $urandom_range(1, 3);
			repeat (gap) @(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	// waits for the next edge before checking, so the count includes a word accepted at the last edge
	task automatic wait_for_results();
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, claims, saturating merge, zero add
		send_word(make_word(OP_FIND, KIND_ANY, 8'd0, 8'd0, 16'd0, 8'd0));
		send_word(make_word(OP_ADD, KIND_WOOD, 8'd0, 8'd0, 16'd1, 8'd0));
		send_word(make_word(OP_ADD, KIND_WOOD, 8'd255, 8'd255, 16'hFFFF, 8'd0));
		send_word(make_word(OP_ADD, KIND_WOOD, 8'd255, 8'd255, 16'hFFFF, 8'd0));
		send_word(make_word(OP_ADD, KIND_STONE, 8'd0, 8'd0, 16'd0, 8'd0));
		// kind none, spare kinds and stone sharing one position
		send_word(make_word(OP_ADD, KIND_ANY, 8'd3, 8'd3, 16'd5, 8'd0));
		send_word(make_word(OP_ADD, KIND_SPARE, 8'd3, 8'd3, 16'd100, 8'd0));
		send_word(make_word(OP_ADD, KIND_STONE, 8'd3, 8'd3, 16'hFFFF, 8'd0));
		send_word(make_word(OP_ADD, KIND_CHAIR, 8'd3, 8'd3, 16'd9, 8'd255));
		send_word(make_word(OP_FIND, KIND_ANY, 8'd3, 8'd3, 16'hFFFF, 8'd255));
		send_word(make_word(OP_FIND, KIND_SPARE, 8'd3, 8'd3, 16'd0, 8'd0));
		send_word(make_word(OP_FIND, KIND_BED, 8'd3, 8'd3, 16'd0, 8'd0));
		send_word(make_word(OP_FIND, KIND_STONE, 8'd255, 8'd255, 16'd0, 8'd0));
		// takes out of range, on an unused slot, of zero, partial and whole
		send_word(make_word(OP_TAKE, KIND_ANY, 8'd0, 8'd0, 16'd1, 8'd255));
		send_word(make_word(OP_TAKE, KIND_ANY, 8'd0, 8'd0, 16'd1, 8'd64));
		send_word(make_word(OP_TAKE, KIND_ANY, 8'd0, 8'd0, 16'd1, 8'd63));
		send_word(make_word(OP_TAKE, KIND_ANY, 8'd0, 8'd0, 16'd0, 8'd1));
		send_word(make_word(OP_TAKE, KIND_ANY, 8'd0, 8'd0, 16'd100, 8'd1));
		send_word(make_word(OP_TAKE, KIND_WOOD, 8'd255, 8'd255, 16'hFFFF, 8'd1));
		send_word(make_word(OP_FIND, KIND_WOOD, 8'd255, 8'd255, 16'd0, 8'd0));
		send_word(make_word(OP_NONE, KIND_SPARE, 8'd255, 8'd255, 16'hFFFF, 8'd255));
		send_word(make_word(OP_ADD, KIND_BED, 8'd255, 8'd0, 16'd7, 8'd0));
		send_word(make_word(OP_TAKE, KIND_ANY, 8'd0, 8'd0, 16'd1, 8'd0));

		repeat (300) send_word(random_word(45, 25, 1'b0));

		// sender holds off until the table has answered everything
		req_valid <= 1'b0;
		wait_for_results();

		// fill the table to overflowing with no idling on either side
		steady <= 1'b1;
		repeat (150) send_word(random_word(90, 5, 1'b1));
		steady <= 1'b0;

		repeat (380) send_word(random_word(30, 55, 1'b0));

		req_valid <= 1'b0;
		wait_for_results();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("stacking_item_table regression: pass");
		else
			$display("stacking_item_table regression: fail");
		$finish;
	end

endmodule
